[src/sip_pkg.sv]
// Shared types, widths and helper functions for the segment intersection block.
package sip_pkg;

	localparam int CW    = 32;
	localparam int EW    = 16;
	localparam int FRAC  = 16;
	localparam int NTEST = 4;
	localparam int DW    = CW + 1;
	localparam int PW    = 2 * DW;
	localparam int XW    = PW + 1;
	localparam int PPW   = 2 * PW;
	localparam int NW    = PW + DW;
	localparam int DENW  = PW + 1;
	localparam int DDW   = DENW + 1;
	localparam int RW    = DDW + 1;
	localparam int QW    = CW + 2;
	localparam int M2W   = NW + 2;

	localparam logic [EW-1:0] EPS_RESET = EW'(1);

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_B_START = 3'd1,
		KIND_B_END   = 3'd2,
		KIND_A_START = 3'd3,
		KIND_A_END   = 3'd4,
		KIND_CROSS   = 3'd5
	} kind_t;

	typedef struct packed {
		logic signed [CW-1:0] a_start_x;
		logic signed [CW-1:0] a_start_y;
		logic signed [CW-1:0] a_end_x;
		logic signed [CW-1:0] a_end_y;
		logic signed [CW-1:0] b_start_x;
		logic signed [CW-1:0] b_start_y;
		logic signed [CW-1:0] b_end_x;
		logic signed [CW-1:0] b_end_y;
	} pair_t;

	typedef struct packed {
		logic                 hit;
		kind_t                hit_kind;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
	} hit_t;

	typedef struct packed {
		pair_t                 pts;
		logic [3:0][PW-1:0]    mag;
		logic [NTEST-1:0]      neg;
		logic [NTEST-1:0]      near;
		logic [NTEST-1:0]      rng;
		logic                  short_a;
		logic                  short_b;
		logic [DENW-1:0]       den;
		logic                  den_neg;
		logic [DW-1:0]         adx;
		logic [DW-1:0]         ady;
		logic                  sdx;
		logic                  sdy;
	} front_t;

	typedef struct packed {
		pair_t          pts;
		kind_t          kind;
		logic [M2W-1:0] mag2_x;
		logic [M2W-1:0] mag2_y;
		logic [DDW-1:0] dd;
		logic           neg_x;
		logic           neg_y;
	} cross_t;

	typedef struct packed {
		pair_t          pts;
		kind_t          kind;
		logic           neg_x;
		logic           neg_y;
		logic [DDW-1:0] dd;
	} div_meta_t;

	typedef struct packed {
		logic [RW-1:0] r;
		logic [QW-1:0] n;
		logic [QW-1:0] q;
	} div_lane_t;

	// one restoring division step: shift in the next dividend bit, subtract if it fits
	function automatic div_lane_t div_next(input div_lane_t a, input logic [DDW-1:0] dd);
		div_lane_t     o;
		logic [RW-1:0] t;
		logic          qb;
		t = {a.r[RW-2:0], a.n[QW-1]};
		if (t >= RW'(dd)) begin
			o.r = t - RW'(dd);
			qb  = 1'b1;
		end else begin
			o.r = t;
			qb  = 1'b0;
		end
		o.n = {a.n[QW-2:0], 1'b0};
		o.q = {a.q[QW-2:0], qb};
		return o;
	endfunction

endpackage

[src/sip_if.sv]
// Handshake channel interfaces for segment pairs, results and the tolerance register.
interface sip_pair_if;
	import sip_pkg::*;
	logic  valid;
	logic  ready;
	pair_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sip_hit_if;
	import sip_pkg::*;
	logic valid;
	logic ready;
	hit_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sip_cfg_if;
	import sip_pkg::*;
	logic          valid;
	logic          ready;
	logic [EW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/sip_front.sv]
// Front pipeline: differences, products, cross products and on-segment flags.
module sip_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ce,
	input  logic                   in_valid,
	input  sip_pkg::pair_t         in_data,
	input  logic [sip_pkg::EW-1:0] eps,
	output logic                   out_valid,
	output sip_pkg::front_t        out_data
);
	import sip_pkg::*;

	logic signed [CW-1:0] px [NTEST];
	logic signed [CW-1:0] py [NTEST];
	logic signed [CW-1:0] sx [NTEST];
	logic signed [CW-1:0] sy [NTEST];
	logic signed [CW-1:0] ex [NTEST];
	logic signed [CW-1:0] ey [NTEST];
	logic signed [DW-1:0] eps_p;
	logic signed [DW-1:0] eps_n;
	logic [2*EW-1:0]      eps_sq;
	logic signed [XW:0]   den;

	logic                 v_s1, v_s2, v_s3, v_s4;
	pair_t                pts_s1, pts_s2, pts_s3;
	logic signed [DW-1:0] dif_s1 [NTEST][4];
	logic signed [DW-1:0] da_s1 [4];
	logic signed [PW-1:0] m1_s2 [NTEST];
	logic signed [PW-1:0] m2_s2 [NTEST];
	logic signed [PW-1:0] sq_s2 [4];
	logic signed [DW-1:0] dax_s2, day_s2, dax_s3, day_s3;
	logic [NTEST-1:0]     near_s2, rng_s2, near_s3, rng_s3;
	logic signed [XW-1:0] cr_s3 [NTEST];
	logic                 short_a_s3, short_b_s3;

	always_comb begin
		px = '{in_data.b_start_x, in_data.b_end_x, in_data.a_start_x, in_data.a_end_x};
		py = '{in_data.b_start_y, in_data.b_end_y, in_data.a_start_y, in_data.a_end_y};
		sx = '{in_data.a_start_x, in_data.a_start_x, in_data.b_start_x, in_data.b_start_x};
		sy = '{in_data.a_start_y, in_data.a_start_y, in_data.b_start_y, in_data.b_start_y};
		ex = '{in_data.a_end_x, in_data.a_end_x, in_data.b_end_x, in_data.b_end_x};
		ey = '{in_data.a_end_y, in_data.a_end_y, in_data.b_end_y, in_data.b_end_y};
	end

	assign eps_p  = DW'(eps);
	assign eps_n  = -eps_p;
	assign eps_sq = (2*EW)'(eps) * (2*EW)'(eps);
	assign den    = (XW+1)'(cr_s3[2]) - (XW+1)'(cr_s3[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pts_s1 <= in_data;
			for (int t = 0; t < NTEST; t++) begin
				dif_s1[t][0] <= DW'(sx[t]) - DW'(px[t]);
				dif_s1[t][1] <= DW'(sy[t]) - DW'(py[t]);
				dif_s1[t][2] <= DW'(ex[t]) - DW'(px[t]);
				dif_s1[t][3] <= DW'(ey[t]) - DW'(py[t]);
			end
			da_s1[0] <= DW'(in_data.a_end_x) - DW'(in_data.a_start_x);
			da_s1[1] <= DW'(in_data.a_end_y) - DW'(in_data.a_start_y);
			da_s1[2] <= DW'(in_data.b_end_x) - DW'(in_data.b_start_x);
			da_s1[3] <= DW'(in_data.b_end_y) - DW'(in_data.b_start_y);

			pts_s2 <= pts_s1;
			for (int t = 0; t < NTEST; t++) begin
				m1_s2[t]   <= dif_s1[t][0] * dif_s1[t][3];
				m2_s2[t]   <= dif_s1[t][1] * dif_s1[t][2];
				near_s2[t] <= (dif_s1[t][0] <= eps_p) && (dif_s1[t][0] >= eps_n) &&
				              (dif_s1[t][1] <= eps_p) && (dif_s1[t][1] >= eps_n);
				rng_s2[t]  <= ((dif_s1[t][0] <= eps_p) || (dif_s1[t][2] <= eps_p)) &&
				              ((dif_s1[t][0] >= eps_n) || (dif_s1[t][2] >= eps_n)) &&
				              ((dif_s1[t][1] <= eps_p) || (dif_s1[t][3] <= eps_p)) &&
				              ((dif_s1[t][1] >= eps_n) || (dif_s1[t][3] >= eps_n));
			end
			for (int k = 0; k < 4; k++) begin
				sq_s2[k] <= da_s1[k] * da_s1[k];
			end
			dax_s2 <= da_s1[0];
			day_s2 <= da_s1[1];

			pts_s3  <= pts_s2;
			for (int t = 0; t < NTEST; t++) begin
				cr_s3[t] <= XW'(m1_s2[t]) - XW'(m2_s2[t]);
			end
			short_a_s3 <= ({1'b0, sq_s2[0]} + {1'b0, sq_s2[1]}) <= (PW+1)'(eps_sq);
			short_b_s3 <= ({1'b0, sq_s2[2]} + {1'b0, sq_s2[3]}) <= (PW+1)'(eps_sq);
			near_s3 <= near_s2;
			rng_s3  <= rng_s2;
			dax_s3  <= dax_s2;
			day_s3  <= day_s2;

			out_data.pts <= pts_s3;
			for (int t = 0; t < NTEST; t++) begin
				out_data.mag[t] <= cr_s3[t][XW-1] ? PW'(-cr_s3[t]) : PW'(cr_s3[t]);
				out_data.neg[t] <= cr_s3[t][XW-1];
			end
			out_data.near    <= near_s3;
			out_data.rng     <= rng_s3;
			out_data.short_a <= short_a_s3;
			out_data.short_b <= short_b_s3;
			out_data.den_neg <= den[XW];
			out_data.den     <= den[XW] ? DENW'(-den) : DENW'(den);
			out_data.adx     <= dax_s3[DW-1] ? DW'(-dax_s3) : DW'(dax_s3);
			out_data.ady     <= day_s3[DW-1] ? DW'(-day_s3) : DW'(day_s3);
			out_data.sdx     <= dax_s3[DW-1];
			out_data.sdy     <= day_s3[DW-1];
		end
	end

	assign out_valid = v_s4;

endmodule

[src/sip_cross.sv]
// Middle pipeline: point-hit priority, crossing sign tests and interpolation numerators.
module sip_cross (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ce,
	input  logic                   in_valid,
	input  sip_pkg::front_t        in_data,
	input  logic [sip_pkg::EW-1:0] eps,
	output logic                   out_valid,
	output sip_pkg::cross_t        out_data
);
	import sip_pkg::*;

	logic [NTEST-1:0] on;
	kind_t            kind_pt;
	logic [PW-1:0]    eps_cr;
	logic [PPW-1:0]   eps_pr;
	logic [DW-1:0]    lo [NTEST];
	logic [DW-1:0]    hi [NTEST];

	logic             v_s5, v_s6, v_s7;
	pair_t            pts_s5, pts_s6;
	kind_t            kind_s5, kind_s6;
	logic             cand_s5, cand_s6;
	logic             neg_x_s5, neg_y_s5, neg_x_s6, neg_y_s6;
	logic [DENW-1:0]  den_s5, den_s6;
	logic [PW-1:0]    pa_s5 [4];
	logic [PW-1:0]    pb_s5 [4];
	logic [PW-1:0]    pnx_s5 [2];
	logic [PW-1:0]    pny_s5 [2];
	logic [PPW-1:0]   pa_s6, pb_s6;
	logic [NW-1:0]    nx_s6, ny_s6;

	assign eps_cr = PW'(eps) << FRAC;
	assign eps_pr = PPW'(eps) << (3*FRAC);

	always_comb begin
		for (int t = 0; t < NTEST; t++) begin
			lo[t] = in_data.mag[t][DW-1:0];
			hi[t] = in_data.mag[t][PW-1:DW];
			on[t] = ((t < 2) ? in_data.short_a : in_data.short_b) ? in_data.near[t] :
			        ((in_data.mag[t] <= eps_cr) && in_data.rng[t]);
		end
		if (on[0]) begin
			kind_pt = KIND_B_START;
		end else if (on[1]) begin
			kind_pt = KIND_B_END;
		end else if (on[2]) begin
			kind_pt = KIND_A_START;
		end else if (on[3]) begin
			kind_pt = KIND_A_END;
		end else begin
			kind_pt = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
		end else if (ce) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pa_s5[0]  <= lo[0] * lo[1];
			pa_s5[1]  <= lo[0] * hi[1];
			pa_s5[2]  <= hi[0] * lo[1];
			pa_s5[3]  <= hi[0] * hi[1];
			pb_s5[0]  <= lo[2] * lo[3];
			pb_s5[1]  <= lo[2] * hi[3];
			pb_s5[2]  <= hi[2] * lo[3];
			pb_s5[3]  <= hi[2] * hi[3];
			pnx_s5[0] <= lo[2] * in_data.adx;
			pnx_s5[1] <= hi[2] * in_data.adx;
			pny_s5[0] <= lo[2] * in_data.ady;
			pny_s5[1] <= hi[2] * in_data.ady;
			neg_x_s5  <= in_data.neg[2] ^ in_data.den_neg ^ in_data.sdx;
			neg_y_s5  <= in_data.neg[2] ^ in_data.den_neg ^ in_data.sdy;
			cand_s5   <= !in_data.short_a && !in_data.short_b &&
			             (in_data.neg[0] ^ in_data.neg[1]) && (in_data.neg[2] ^ in_data.neg[3]);
			kind_s5   <= kind_pt;
			den_s5    <= in_data.den;
			pts_s5    <= in_data.pts;

			pa_s6    <= PPW'(pa_s5[0]) + (PPW'(pa_s5[1]) << DW) + (PPW'(pa_s5[2]) << DW) +
			            (PPW'(pa_s5[3]) << PW);
			pb_s6    <= PPW'(pb_s5[0]) + (PPW'(pb_s5[1]) << DW) + (PPW'(pb_s5[2]) << DW) +
			            (PPW'(pb_s5[3]) << PW);
			nx_s6    <= NW'(pnx_s5[0]) + (NW'(pnx_s5[1]) << DW);
			ny_s6    <= NW'(pny_s5[0]) + (NW'(pny_s5[1]) << DW);
			neg_x_s6 <= neg_x_s5;
			neg_y_s6 <= neg_y_s5;
			cand_s6  <= cand_s5;
			kind_s6  <= kind_s5;
			den_s6   <= den_s5;
			pts_s6   <= pts_s5;

			out_data.pts    <= pts_s6;
			out_data.kind   <= (kind_s6 != KIND_NONE) ? kind_s6 :
			                   ((cand_s6 && (pa_s6 > eps_pr) && (pb_s6 > eps_pr)) ?
			                    KIND_CROSS : KIND_NONE);
			out_data.mag2_x <= (M2W'(nx_s6) << 1) + M2W'(den_s6);
			out_data.mag2_y <= (M2W'(ny_s6) << 1) + M2W'(den_s6);
			out_data.dd     <= DDW'(den_s6) << 1;
			out_data.neg_x  <= neg_x_s6;
			out_data.neg_y  <= neg_y_s6;
		end
	end

	assign out_valid = v_s7;

endmodule

[src/sip_div.sv]
// Pipelined restoring divider: one quotient bit per stage for both axes.
module sip_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ce,
	input  logic                   in_valid,
	input  sip_pkg::cross_t        in_data,
	output logic                   out_valid,
	output sip_pkg::div_meta_t     out_meta,
	output logic [sip_pkg::QW-1:0] out_qx,
	output logic [sip_pkg::QW-1:0] out_qy
);
	import sip_pkg::*;

	logic [QW-1:0] v_s;
	div_meta_t     meta_s [QW];
	div_lane_t     lx_s [QW];
	div_lane_t     ly_s [QW];
	div_lane_t     lx0, ly0;
	div_meta_t     meta0;

	assign lx0   = '{r: RW'(in_data.mag2_x >> QW), n: in_data.mag2_x[QW-1:0], q: '0};
	assign ly0   = '{r: RW'(in_data.mag2_y >> QW), n: in_data.mag2_y[QW-1:0], q: '0};
	assign meta0 = '{pts: in_data.pts, kind: in_data.kind, neg_x: in_data.neg_x,
	                 neg_y: in_data.neg_y, dd: in_data.dd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (ce) begin
			v_s <= {v_s[QW-2:0], in_valid};
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ce) begin
					lx_s[k]   <= div_next(lx0, meta0.dd);
					ly_s[k]   <= div_next(ly0, meta0.dd);
					meta_s[k] <= meta0;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (ce) begin
					lx_s[k]   <= div_next(lx_s[k-1], meta_s[k-1].dd);
					ly_s[k]   <= div_next(ly_s[k-1], meta_s[k-1].dd);
					meta_s[k] <= meta_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign out_meta  = meta_s[QW-1];
	assign out_qx    = lx_s[QW-1].q;
	assign out_qy    = ly_s[QW-1].q;

endmodule

[src/segment_intersection_point.sv]
// Top level of the 2D segment intersection pipeline.
// Channels: pairs carries one segment pair (A start/end, B start/end, signed Q16.16)
// per transfer; hits returns one result per pair (hit, hit_kind, hit_x, hit_y), in
// input order. cfg writes the 16-bit epsilon tolerance; write it only while idle.
// Point-on-segment checks run first (B start, B end, A start, A end), then the proper
// crossing, whose point is found by a pipelined divider.
// Stages from a pairs transfer to hits.valid: 4 front stages, 3 product stages, 34
// divider stages and 1 output register.
// Throughput: one pair per cycle unless hits stalls; that rate fills every stage.
// Stall: when hits.valid is high and hits.ready low, every stage holds and pairs.ready
// drops; nothing is dropped or repeated. cfg.ready is always high.
// Reset: arst_n clears all valid bits and sets epsilon to 1.
module segment_intersection_point (
	input logic      clk,
	input logic      arst_n,
	sip_cfg_if.sink  cfg,
	sip_pair_if.sink pairs,
	sip_hit_if.source hits
);
	import sip_pkg::*;

	logic               ce;
	logic [EW-1:0]      eps_q;
	logic               f_valid;
	front_t             f_data;
	logic               c_valid;
	cross_t             c_data;
	logic               d_valid;
	div_meta_t          d_meta;
	logic [QW-1:0]      d_qx, d_qy;
	logic signed [QW:0] sqx, sqy, hx, hy;
	hit_t               res;
	logic               vo_q;
	hit_t               out_q;

	assign ce          = !vo_q || hits.ready;
	assign pairs.ready = ce;
	assign cfg.ready   = 1'b1;
	assign hits.valid  = vo_q;
	assign hits.data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg.valid) begin
			eps_q <= cfg.data;
		end
	end

	sip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (pairs.valid),
		.in_data   (pairs.data),
		.eps       (eps_q),
		.out_valid (f_valid),
		.out_data  (f_data)
	);

	sip_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (f_valid),
		.in_data   (f_data),
		.eps       (eps_q),
		.out_valid (c_valid),
		.out_data  (c_data)
	);

	sip_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (c_valid),
		.in_data   (c_data),
		.out_valid (d_valid),
		.out_meta  (d_meta),
		.out_qx    (d_qx),
		.out_qy    (d_qy)
	);

	always_comb begin
		sqx = d_meta.neg_x ? -$signed({1'b0, d_qx}) : $signed({1'b0, d_qx});
		sqy = d_meta.neg_y ? -$signed({1'b0, d_qy}) : $signed({1'b0, d_qy});
		hx  = sqx + (QW+1)'(d_meta.pts.a_start_x);
		hy  = sqy + (QW+1)'(d_meta.pts.a_start_y);
		res.hit      = (d_meta.kind != KIND_NONE);
		res.hit_kind = d_meta.kind;
		res.hit_x    = '0;
		res.hit_y    = '0;
		case (d_meta.kind)
			KIND_B_START: begin
				res.hit_x = d_meta.pts.b_start_x;
				res.hit_y = d_meta.pts.b_start_y;
			end
			KIND_B_END: begin
				res.hit_x = d_meta.pts.b_end_x;
				res.hit_y = d_meta.pts.b_end_y;
			end
			KIND_A_START: begin
				res.hit_x = d_meta.pts.a_start_x;
				res.hit_y = d_meta.pts.a_start_y;
			end
			KIND_A_END: begin
				res.hit_x = d_meta.pts.a_end_x;
				res.hit_y = d_meta.pts.a_end_y;
			end
			KIND_CROSS: begin
				res.hit_x = hx[CW-1:0];
				res.hit_y = hy[CW-1:0];
			end
			default: begin
				res.hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (ce) begin
			vo_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_q <= res;
		end
	end

	a_hit_kind: assert property (@(posedge clk) disable iff (!arst_n)
		hits.valid |-> (hits.data.hit == (hits.data.hit_kind != KIND_NONE)))
		else $error("hit flag disagrees with hit kind");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(hits.valid && !hits.data.hit) |-> (hits.data.hit_x == '0 && hits.data.hit_y == '0))
		else $error("miss carries a nonzero point");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(hits.valid && !hits.ready) |-> !pairs.ready)
		else $error("input accepted while output stalled");

endmodule
